/* rtl/cga_pkg.sv */
// ----------------------------------------------------------------------------
// cga_pkg
// Shared constants, command/status types and lookup functions for the
// codon greedy aligner.
// ----------------------------------------------------------------------------
package cga_pkg;

  localparam int REF_DEPTH = 65536;
  localparam int QUERY_DEPTH = 4096;
  localparam int REF_AW = $clog2(REF_DEPTH);
  localparam int QRY_AW = $clog2(QUERY_DEPTH);
  localparam int REF_LW = REF_AW + 1;
  localparam int QRY_LW = QRY_AW + 1;
  // walk positions can run one skip past the longer sequence
  localparam int POS_W = REF_LW + 1;
  localparam int CQ_W = POS_W - 2;
  localparam int PEN_W = 20;
  localparam int CAND_NUM = 24;
  localparam int CAND_W = 5;

  // datapath operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_INIT = 4'd1;
  localparam logic [3:0] OP_FETCH_MAIN = 4'd2;
  localparam logic [3:0] OP_FETCH_CAND = 4'd3;
  localparam logic [3:0] OP_STEP = 4'd4;
  localparam logic [3:0] OP_SCANF_INIT = 4'd5;
  localparam logic [3:0] OP_SCANB_INIT = 4'd6;
  localparam logic [3:0] OP_SCAN = 4'd7;
  localparam logic [3:0] OP_SKIP = 4'd8;
  localparam logic [3:0] OP_CAND_NEXT = 4'd9;
  localparam logic [3:0] OP_SHIFT = 4'd10;
  localparam logic [3:0] OP_MUL = 4'd11;
  localparam logic [3:0] OP_SUB = 4'd12;
  localparam logic [3:0] OP_FAIL = 4'd13;
  localparam logic [3:0] OP_RESULT = 4'd14;

  localparam logic [7:0] AMINO_UNKNOWN = 8'h3F;
  localparam logic [8*64-1:0] AMINO_TABLE =
    "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

  typedef struct packed {
    logic [3:0] op;
    logic       load_en;
  } cmd_t;

  typedef struct packed {
    logic walk_go;
    logic loop_ok;
    logic fetch_done;
    logic main_eq;
    logic scan_done;
    logic homo;
    logic cand_end;
    logic cand_ok;
    logic cand_eq;
    logic fail_hit;
    logic out_busy;
  } stat_t;

  // shifted-match candidate: offsets are 3+di and 3+dj, cost is dist+3
  typedef struct packed {
    logic [2:0] ddi;
    logic [2:0] ddj;
    logic [2:0] cost;
  } cand_t;

  typedef logic [2:0][7:0] triple_t;

  // candidates sorted by distance, then di, then dj
  function automatic cand_t cand_entry(input logic [CAND_W-1:0] idx);
    cand_t c;
    c = '0;
    unique case (idx)
      5'd0:  c = '{3'd2, 3'd3, 3'd4};
      5'd1:  c = '{3'd3, 3'd2, 3'd4};
      5'd2:  c = '{3'd3, 3'd4, 3'd4};
      5'd3:  c = '{3'd4, 3'd3, 3'd4};
      5'd4:  c = '{3'd1, 3'd3, 3'd5};
      5'd5:  c = '{3'd2, 3'd2, 3'd5};
      5'd6:  c = '{3'd2, 3'd4, 3'd5};
      5'd7:  c = '{3'd3, 3'd1, 3'd5};
      5'd8:  c = '{3'd3, 3'd5, 3'd5};
      5'd9:  c = '{3'd4, 3'd2, 3'd5};
      5'd10: c = '{3'd4, 3'd4, 3'd5};
      5'd11: c = '{3'd5, 3'd3, 3'd5};
      5'd12: c = '{3'd1, 3'd2, 3'd6};
      5'd13: c = '{3'd1, 3'd4, 3'd6};
      5'd14: c = '{3'd2, 3'd1, 3'd6};
      5'd15: c = '{3'd2, 3'd5, 3'd6};
      5'd16: c = '{3'd4, 3'd1, 3'd6};
      5'd17: c = '{3'd4, 3'd5, 3'd6};
      5'd18: c = '{3'd5, 3'd2, 3'd6};
      5'd19: c = '{3'd5, 3'd4, 3'd6};
      5'd20: c = '{3'd1, 3'd1, 3'd7};
      5'd21: c = '{3'd1, 3'd5, 3'd7};
      5'd22: c = '{3'd5, 3'd1, 3'd7};
      5'd23: c = '{3'd5, 3'd5, 3'd7};
      default: c = '0;
    endcase
    return c;
  endfunction

  // base code in T, C, A, G order; bit 2 flags an unknown byte
  function automatic logic [2:0] base_code(input logic [7:0] b);
    logic [2:0] r;
    r = 3'b100;
    case (b)
      8'h54: r = 3'd0;
      8'h43: r = 3'd1;
      8'h41: r = 3'd2;
      8'h47: r = 3'd3;
      default: r = 3'b100;
    endcase
    return r;
  endfunction

  // translate a codon (byte 0 first) to its amino acid letter
  function automatic logic [7:0] amino_of(input triple_t c);
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] d;
    logic [5:0] k;
    a = base_code(c[0]);
    b = base_code(c[1]);
    d = base_code(c[2]);
    k = {a[1:0], b[1:0], d[1:0]};
    if (a[2] || b[2] || d[2]) begin
      return AMINO_UNKNOWN;
    end
    return AMINO_TABLE[8*(63-int'(k)) +: 8];
  endfunction

endpackage

/* rtl/cga_ram.sv */
// ----------------------------------------------------------------------------
// cga_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cga_ctrl.sv */
// ----------------------------------------------------------------------------
// cga_ctrl
// Walk sequencer: steps the datapath through load, codon compare, run scan,
// shifted-match search, substitution scoring and the penalty bound check.
// ----------------------------------------------------------------------------
module cga_ctrl import cga_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOP = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_EQ = 4'd3;
  localparam logic [3:0] S_SCANF = 4'd4;
  localparam logic [3:0] S_SCANB = 4'd5;
  localparam logic [3:0] S_HOMO = 4'd6;
  localparam logic [3:0] S_CAND = 4'd7;
  localparam logic [3:0] S_CFETCH = 4'd8;
  localparam logic [3:0] S_CCMP = 4'd9;
  localparam logic [3:0] S_MUL = 4'd10;
  localparam logic [3:0] S_SUB = 4'd11;
  localparam logic [3:0] S_CHK = 4'd12;
  localparam logic [3:0] S_FIN = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    cmd.load_en = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.load_en = 1'b1;
        if (stat.walk_go) begin
          cmd.op = OP_INIT;
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        state_next = stat.loop_ok ? S_FETCH : S_FIN;
      end
      S_FETCH: begin
        cmd.op = OP_FETCH_MAIN;
        if (stat.fetch_done) begin
          state_next = S_EQ;
        end
      end
      S_EQ: begin
        if (stat.main_eq) begin
          cmd.op = OP_STEP;
          state_next = S_LOOP;
        end else begin
          cmd.op = OP_SCANF_INIT;
          state_next = S_SCANF;
        end
      end
      S_SCANF: begin
        if (stat.scan_done) begin
          cmd.op = OP_SCANB_INIT;
          state_next = S_SCANB;
        end else begin
          cmd.op = OP_SCAN;
        end
      end
      S_SCANB: begin
        if (stat.scan_done) begin
          state_next = S_HOMO;
        end else begin
          cmd.op = OP_SCAN;
        end
      end
      S_HOMO: begin
        if (stat.homo) begin
          cmd.op = OP_SKIP;
          state_next = S_LOOP;
        end else begin
          state_next = S_CAND;
        end
      end
      S_CAND: begin
        if (stat.cand_end) begin
          state_next = S_MUL;
        end else if (stat.cand_ok) begin
          state_next = S_CFETCH;
        end else begin
          cmd.op = OP_CAND_NEXT;
        end
      end
      S_CFETCH: begin
        cmd.op = OP_FETCH_CAND;
        if (stat.fetch_done) begin
          state_next = S_CCMP;
        end
      end
      S_CCMP: begin
        if (stat.cand_eq) begin
          cmd.op = OP_SHIFT;
          state_next = S_CHK;
        end else begin
          cmd.op = OP_CAND_NEXT;
          state_next = S_CAND;
        end
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.op = OP_SUB;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.fail_hit) begin
          cmd.op = OP_FAIL;
          state_next = S_FIN;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.op = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/cga_dp.sv */
// ----------------------------------------------------------------------------
// cga_dp
// Aligner datapath: sequence stores, walk positions, run counters, candidate
// index, penalty accumulator and the result register.
// ----------------------------------------------------------------------------
module cga_dp import cga_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic             in_valid,
  input  logic             mode,
  input  logic [7:0]       base_char,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PEN_W-1:0] penalty,
  output logic             failed
);

  // load state
  logic [REF_LW-1:0] ref_len;
  logic [QRY_LW-1:0] qry_len;
  logic              loading;

  // walk state
  logic [POS_W-1:0]  pi;
  logic [POS_W-1:0]  pj;
  logic [CQ_W-1:0]   iq;
  logic [CQ_W-1:0]   jq;
  logic [1:0]        ir;
  logic [1:0]        jr;
  logic [PEN_W-1:0]  total;
  logic              fail_flag;
  triple_t           r0;
  triple_t           q0;
  triple_t           rt;
  triple_t           qt;
  logic [1:0]        fcnt;
  logic [CAND_W-1:0] cand;

  // run scan state
  logic              dir_back;
  logic              phase;
  logic              r_act;
  logic              q_act;
  logic [REF_LW-1:0] rk;
  logic [QRY_LW-1:0] qk;
  logic [REF_LW-1:0] hr;
  logic [QRY_LW-1:0] hq;
  logic [CQ_W-1:0]   hr_q;
  logic [1:0]        hr_r;
  logic [CQ_W-1:0]   hq_q;
  logic [1:0]        hq_r;

  // substitution scoring
  logic [27:0]       d2;
  logic [25:0]       qsq;
  logic              aeq;

  // memories
  logic              ref_we;
  logic              qry_we;
  logic [REF_AW-1:0] ref_waddr;
  logic [QRY_AW-1:0] qry_waddr;
  logic [REF_AW-1:0] ref_raddr;
  logic [QRY_AW-1:0] qry_raddr;
  logic [7:0]        ref_rd;
  logic [7:0]        qry_rd;

  logic              acc;
  logic [REF_LW-1:0] ref_eff;
  logic [QRY_LW-1:0] qry_eff;
  logic              ref_room;
  logic              qry_room;
  cand_t             ce;
  logic [POS_W-1:0]  ci;
  logic [POS_W-1:0]  cj;
  logic [POS_W-1:0]  fi;
  logic [POS_W-1:0]  fj;
  logic              is_fetch;
  logic [CQ_W-1:0]   cmax;
  logic [CQ_W+2:0]   c5;
  logic              hp_from_q;
  logic [CQ_W-1:0]   sq;
  logic [POS_W-1:0]  skip3;
  logic signed [14:0] dd;
  logic [13:0]       dabs;
  logic [30:0]       d6;
  logic [2:0]        sub_cost;

  // advance a base-3 split position by a small offset
  function automatic logic [CQ_W+1:0] adv3(input logic [CQ_W-1:0] q, input logic [1:0] r,
                                           input logic [2:0] dlt);
    logic [2:0] s;
    logic [CQ_W-1:0] nq;
    logic [1:0] nr;
    s = 3'(r) + dlt;
    if (s >= 3'd6) begin
      nq = q + CQ_W'(2);
      nr = 2'(s - 3'd6);
    end else if (s >= 3'd3) begin
      nq = q + CQ_W'(1);
      nr = 2'(s - 3'd3);
    end else begin
      nq = q;
      nr = s[1:0];
    end
    return {nq, nr};
  endfunction

  // load side: store writes
  assign acc = in_valid && cmd.load_en;
  assign ref_eff = loading ? '0 : ref_len;
  assign qry_eff = loading ? '0 : qry_len;
  assign ref_room = ref_eff < REF_LW'(REF_DEPTH);
  assign qry_room = qry_eff < QRY_LW'(QUERY_DEPTH);
  assign ref_we = acc && !mode && ref_room;
  assign qry_we = acc && mode && qry_room;
  assign ref_waddr = ref_eff[REF_AW-1:0];
  assign qry_waddr = qry_eff[QRY_AW-1:0];

  // candidate positions and fetch base
  assign ce = cand_entry(cand);
  assign ci = pi + POS_W'(ce.ddi);
  assign cj = pj + POS_W'(ce.ddj);
  assign is_fetch = (cmd.op == OP_FETCH_MAIN) || (cmd.op == OP_FETCH_CAND);
  assign fi = (cmd.op == OP_FETCH_MAIN) ? pi : ci;
  assign fj = (cmd.op == OP_FETCH_MAIN) ? pj : cj;

  // read address: fetch window or scan pointer
  always_comb begin
    if (is_fetch) begin
      ref_raddr = REF_AW'(fi + POS_W'(fcnt));
      qry_raddr = QRY_AW'(fj + POS_W'(fcnt));
    end else if (dir_back) begin
      ref_raddr = REF_AW'(rk - REF_LW'(1));
      qry_raddr = QRY_AW'(qk - QRY_LW'(1));
    end else begin
      ref_raddr = rk[REF_AW-1:0];
      qry_raddr = qk[QRY_AW-1:0];
    end
  end

  // homopolymer skip: longer qualifying run, in codons
  assign hp_from_q = (hq >= QRY_LW'(3)) &&
                     ((hr < REF_LW'(3)) || (REF_LW'(hq) > hr));
  assign sq = hp_from_q ? hq_q : hr_q;
  assign skip3 = POS_W'({sq, 1'b0}) + POS_W'(sq);

  // substitution distance from the query center
  assign dd = $signed({1'b0, pj[QRY_LW-1:0], 1'b0}) - $signed({2'b0, qry_len});
  assign dabs = dd[14] ? 14'(-dd) : 14'(dd);
  assign d6 = {1'b0, d2, 2'b0} + {2'b0, d2, 1'b0};
  assign sub_cost = aeq ? 3'd1 : ((d6 <= 31'(qsq)) ? 3'd5 : 3'd4);

  // penalty bound
  assign cmax = (iq > jq) ? iq : jq;
  assign c5 = {cmax, 2'b0} + (CQ_W+3)'(cmax);

  // status to the controller
  always_comb begin
    stat.walk_go = acc && mode && last;
    stat.loop_ok = ((POS_W+1)'(pi) + (POS_W+1)'(2) < (POS_W+1)'(ref_len)) &&
                   ((POS_W+1)'(pj) + (POS_W+1)'(2) < (POS_W+1)'(qry_len));
    stat.fetch_done = (fcnt == 2'd3);
    stat.main_eq = (r0 == q0);
    stat.scan_done = !r_act && !q_act;
    stat.homo = (hr >= REF_LW'(3)) || (hq >= QRY_LW'(3));
    stat.cand_end = (cand == CAND_W'(CAND_NUM));
    stat.cand_ok = ((POS_W+1)'(ci) + (POS_W+1)'(2) < (POS_W+1)'(ref_len)) &&
                   ((POS_W+1)'(cj) + (POS_W+1)'(2) < (POS_W+1)'(qry_len));
    stat.cand_eq = (rt == qt);
    stat.fail_hit = (cmax > CQ_W'(10)) && (total > PEN_W'(c5));
    stat.out_busy = out_valid;
  end

  // control registers: lengths, load flag, result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len <= '0;
      qry_len <= '0;
      loading <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        if (!mode) begin
          ref_len <= ref_room ? ref_eff + REF_LW'(1) : ref_eff;
        end else begin
          qry_len <= qry_room ? qry_eff + QRY_LW'(1) : qry_eff;
        end
        loading <= last;
      end
      if (cmd.op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: begin
        pi <= '0;
        pj <= '0;
        iq <= '0;
        jq <= '0;
        ir <= '0;
        jr <= '0;
        total <= '0;
        fail_flag <= 1'b0;
        fcnt <= '0;
        dir_back <= 1'b0;
      end
      OP_FETCH_MAIN, OP_FETCH_CAND: begin
        fcnt <= (fcnt == 2'd3) ? 2'd0 : fcnt + 2'd1;
        if (fcnt != 2'd0) begin
          if (cmd.op == OP_FETCH_MAIN) begin
            r0[fcnt - 2'd1] <= ref_rd;
            q0[fcnt - 2'd1] <= qry_rd;
          end else begin
            rt[fcnt - 2'd1] <= ref_rd;
            qt[fcnt - 2'd1] <= qry_rd;
          end
        end
      end
      OP_STEP: begin
        pi <= pi + POS_W'(3);
        pj <= pj + POS_W'(3);
        iq <= iq + CQ_W'(1);
        jq <= jq + CQ_W'(1);
      end
      OP_SCANF_INIT, OP_SCANB_INIT: begin
        dir_back <= (cmd.op == OP_SCANB_INIT);
        phase <= 1'b0;
        r_act <= 1'b1;
        q_act <= 1'b1;
        cand <= '0;
        if (cmd.op == OP_SCANF_INIT) begin
          rk <= REF_LW'(pi) + REF_LW'(1);
          qk <= QRY_LW'(pj) + QRY_LW'(1);
          hr <= REF_LW'(1);
          hq <= QRY_LW'(1);
          hr_q <= '0;
          hr_r <= 2'd1;
          hq_q <= '0;
          hq_r <= 2'd1;
        end else begin
          rk <= REF_LW'(pi);
          qk <= QRY_LW'(pj);
        end
      end
      OP_SCAN: begin
        phase <= !phase;
        if (!phase) begin
          // drop a stream that has hit its end
          if (dir_back ? (rk == '0) : (rk >= ref_len)) begin
            r_act <= 1'b0;
          end
          if (dir_back ? (qk == '0) : (qk >= qry_len)) begin
            q_act <= 1'b0;
          end
        end else begin
          if (r_act) begin
            if (ref_rd == r0[0]) begin
              hr <= hr + REF_LW'(1);
              hr_q <= (hr_r == 2'd2) ? hr_q + CQ_W'(1) : hr_q;
              hr_r <= (hr_r == 2'd2) ? 2'd0 : hr_r + 2'd1;
              rk <= dir_back ? rk - REF_LW'(1) : rk + REF_LW'(1);
            end else begin
              r_act <= 1'b0;
            end
          end
          if (q_act) begin
            if (qry_rd == q0[0]) begin
              hq <= hq + QRY_LW'(1);
              hq_q <= (hq_r == 2'd2) ? hq_q + CQ_W'(1) : hq_q;
              hq_r <= (hq_r == 2'd2) ? 2'd0 : hq_r + 2'd1;
              qk <= dir_back ? qk - QRY_LW'(1) : qk + QRY_LW'(1);
            end else begin
              q_act <= 1'b0;
            end
          end
        end
      end
      OP_SKIP: begin
        pi <= pi + skip3;
        pj <= pj + skip3;
        iq <= iq + sq;
        jq <= jq + sq;
        total <= total + PEN_W'(2);
      end
      OP_CAND_NEXT: begin
        cand <= cand + CAND_W'(1);
      end
      OP_SHIFT: begin
        pi <= ci;
        pj <= cj;
        {iq, ir} <= adv3(iq, ir, ce.ddi);
        {jq, jr} <= adv3(jq, jr, ce.ddj);
        total <= total + PEN_W'(ce.cost);
      end
      OP_MUL: begin
        d2 <= dabs * dabs;
        qsq <= qry_len * qry_len;
        aeq <= (amino_of(r0) == amino_of(q0));
      end
      OP_SUB: begin
        pi <= pi + POS_W'(3);
        pj <= pj + POS_W'(3);
        iq <= iq + CQ_W'(1);
        jq <= jq + CQ_W'(1);
        total <= total + PEN_W'(sub_cost);
      end
      OP_FAIL: begin
        fail_flag <= 1'b1;
      end
      OP_RESULT: begin
        penalty <= fail_flag ? '0 : total;
        failed <= fail_flag;
      end
      default: begin
      end
    endcase
  end

  cga_ram #(.WIDTH(8), .DEPTH(REF_DEPTH)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (base_char),
    .raddr (ref_raddr),
    .rdata (ref_rd)
  );

  cga_ram #(.WIDTH(8), .DEPTH(QUERY_DEPTH)) u_qry_ram (
    .clk   (clk),
    .we    (qry_we),
    .waddr (qry_waddr),
    .wdata (base_char),
    .raddr (qry_raddr),
    .rdata (qry_rd)
  );

endmodule

/* rtl/codon_greedy_aligner.sv */
// ----------------------------------------------------------------------------
// codon_greedy_aligner
// Codon-level greedy aligner of a query against a stored reference.
// ----------------------------------------------------------------------------
// Reference and query bytes stream in one word per cycle (mode selects the
// store, last ends a sequence). A query word with last set starts the walk;
// no input word is taken until it finishes, and one result word follows.
// The walk fetches each codon from both stores one byte per cycle; an equal
// codon steps on, a mismatch scans the runs around both positions, then
// skips a homopolymer run or tries up to 24 candidate windows and scores
// a substitution if none matches. Loading runs at one word per cycle.
module codon_greedy_aligner import cga_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [7:0]       base_char,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PEN_W-1:0] penalty,
  output logic             failed
);

  cmd_t  cmd;
  stat_t stat;

  assign in_ready = cmd.load_en;

  cga_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  cga_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (in_valid),
    .mode      (mode),
    .base_char (base_char),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .penalty   (penalty),
    .failed    (failed)
  );

endmodule

/* rtl/cga_checker.sv */
// ----------------------------------------------------------------------------
// cga_checker
// Port-level checks for the codon greedy aligner, bound to the top level.
// ----------------------------------------------------------------------------
module cga_checker import cga_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             mode,
  input logic             last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PEN_W-1:0] penalty,
  input logic             failed
);

  // hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(penalty) && $stable(failed))
    else $error("result word changed while stalled");

  // a failed walk reports zero penalty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> penalty == '0)
    else $error("failed result with nonzero penalty");

  // a final query word starts the walk and blocks input
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode && last |=> !in_ready)
    else $error("input taken right after final query word");

  // a new result only appears after the input side was held off
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a walk");

endmodule

bind codon_greedy_aligner cga_checker u_cga_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .mode      (mode),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .penalty   (penalty),
  .failed    (failed)
);
